### src/bta_pkg.sv
package bta_pkg;

	// pool geometry
	localparam int unsigned NUM_BLOCKS  = 8192;
	localparam int unsigned BLOCK_BYTES = 1024;
	localparam int unsigned IDX_W       = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam int unsigned BYTE_SH     = $clog2(BLOCK_BYTES);

	// field widths
	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned OFF_W   = 24;
	localparam int unsigned AOFF_W  = 23;
	localparam int unsigned USAGE_W = 10;
	localparam int unsigned NEED_W  = SIZE_W + 1 - BYTE_SH;

	// usage scaling
	localparam int unsigned PERMILLE = 1000;
	localparam int unsigned PROD_W   = 24;

	// beat widths
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 40;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NOFIT = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic              op;
		logic [SIZE_W-1:0] req_size;
		logic [OFF_W-1:0]  free_offset;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [AOFF_W-1:0]  alloc_offset;
		logic [USAGE_W-1:0] usage_permille;
	} res_t;

	// table port driven by the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [CNT_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} tbl_port_t;

endpackage

### src/bta_table_ram.sv
module bta_table_ram (
	input  logic                 clk,
	input  bta_pkg::tbl_port_t   port,
	output logic [bta_pkg::CNT_W-1:0] rdata
);

	logic [bta_pkg::CNT_W-1:0] mem_q [bta_pkg::NUM_BLOCKS];

	// one write and one registered read each cycle
	always_ff @(posedge clk) begin
		if (port.we) begin
			mem_q[port.waddr] <= port.wdata;
		end
		rdata <= mem_q[port.raddr];
	end

endmodule

### src/bta_core.sv
module bta_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bta_pkg::req_t      req,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_ready,
	output bta_pkg::res_t      res
);

	typedef enum logic [8:0] {
		S_INIT = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_SCAN = 9'b000000100,
		S_MARK = 9'b000001000,
		S_FRD  = 9'b000010000,
		S_FCNT = 9'b000100000,
		S_CLR  = 9'b001000000,
		S_MUL  = 9'b010000000,
		S_EMIT = 9'b100000000
	} state_t;

	localparam int unsigned IW = bta_pkg::IDX_W;
	localparam int unsigned CW = bta_pkg::CNT_W;
	localparam int unsigned SH = bta_pkg::BYTE_SH;

	state_t                         state_q;
	logic [CW-1:0]                  iss_q;
	logic                           have_q;
	logic [CW-1:0]                  run_q;
	logic [CW-1:0]                  need_q;
	logic [IW-1:0]                  pos_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  used_q;
	logic [bta_pkg::PROD_W-1:0]     prod_q;
	bta_pkg::status_t               status_q;
	logic [bta_pkg::AOFF_W-1:0]     aoff_q;
	logic [bta_pkg::OFF_W-1:0]      foff_q;

	bta_pkg::tbl_port_t             tp;
	logic [CW-1:0]                  rdata;
	logic [CW-1:0]                  iss_m1;
	logic [CW-1:0]                  run_n;
	logic                           match;
	logic                           clr_issue;
	logic [bta_pkg::SIZE_W:0]       size_sum;
	logic [bta_pkg::NEED_W-1:0]     need_full;

	bta_table_ram u_ram (
		.clk   (clk),
		.port  (tp),
		.rdata (rdata)
	);

	// shared counter and compare
	assign iss_m1    = iss_q - CW'(1);
	assign run_n     = (rdata == '0) ? (run_q + CW'(1)) : '0;
	assign match     = have_q && (run_n == need_q);
	assign clr_issue = (cnt_q != '0) && !iss_q[CW-1];
	assign size_sum  = {1'b0, req.req_size} + (bta_pkg::SIZE_W+1)'(bta_pkg::BLOCK_BYTES - 1);
	assign need_full = size_sum[bta_pkg::SIZE_W:SH];

	// table port selection
	always_comb begin
		tp = '0;
		case (state_q)
			S_INIT: begin
				tp.we    = 1'b1;
				tp.waddr = iss_q[IW-1:0];
			end
			S_SCAN: begin
				tp.raddr = iss_m1[IW-1:0];
			end
			S_MARK: begin
				tp.we    = 1'b1;
				tp.waddr = pos_q + cnt_q[IW-1:0];
				tp.wdata = need_q;
			end
			S_FRD: begin
				tp.raddr = foff_q[SH+IW-1:SH];
			end
			S_CLR: begin
				tp.raddr = iss_q[IW-1:0];
				tp.we    = have_q && (rdata != '0);
				tp.waddr = iss_m1[IW-1:0];
			end
			default: begin
				tp = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			iss_q    <= '0;
			have_q   <= 1'b0;
			used_q   <= '0;
			status_q <= bta_pkg::ST_OK;
			aoff_q   <= '0;
		end else begin
			case (state_q)
				// clearing sweep after reset
				S_INIT: begin
					iss_q <= iss_q + CW'(1);
					if (iss_q[IW-1:0] == IW'(bta_pkg::NUM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				// decode request
				S_IDLE: begin
					if (start) begin
						foff_q   <= req.free_offset;
						aoff_q   <= '0;
						status_q <= bta_pkg::ST_OK;
						have_q   <= 1'b0;
						if (req.op == bta_pkg::OP_ALLOC) begin
							if (req.req_size == '0) begin
								status_q <= bta_pkg::ST_ZERO;
								state_q  <= S_MUL;
							end else if (need_full >
								bta_pkg::NEED_W'(bta_pkg::NUM_BLOCKS)) begin
								status_q <= bta_pkg::ST_NOFIT;
								state_q  <= S_MUL;
							end else begin
								need_q  <= need_full[CW-1:0];
								iss_q   <= CW'(bta_pkg::NUM_BLOCKS);
								run_q   <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							if (req.free_offset[bta_pkg::OFF_W-1:SH+IW] != '0) begin
								status_q <= bta_pkg::ST_RANGE;
								state_q  <= S_MUL;
							end else begin
								state_q <= S_FRD;
							end
						end
					end
				end
				// top-down scan, one entry a cycle
				S_SCAN: begin
					if (have_q) begin
						run_q <= run_n;
					end
					if (match) begin
						pos_q   <= iss_q[IW-1:0];
						aoff_q  <= bta_pkg::AOFF_W'({iss_q[IW-1:0], SH'(0)});
						cnt_q   <= '0;
						have_q  <= 1'b0;
						state_q <= S_MARK;
					end else if (have_q && (iss_q == '0)) begin
						status_q <= bta_pkg::ST_NOFIT;
						have_q   <= 1'b0;
						state_q  <= S_MUL;
					end else begin
						iss_q  <= iss_m1;
						have_q <= 1'b1;
					end
				end
				// write run length over the run
				S_MARK: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == need_q - CW'(1)) begin
						used_q  <= used_q + need_q;
						state_q <= S_MUL;
					end
				end
				S_FRD: begin
					state_q <= S_FCNT;
				end
				// run length of the freed block
				S_FCNT: begin
					if (rdata == '0) begin
						state_q <= S_MUL;
					end else begin
						cnt_q   <= rdata;
						iss_q   <= {1'b0, foff_q[SH+IW-1:SH]};
						have_q  <= 1'b0;
						state_q <= S_CLR;
					end
				end
				// read then clear each entry, clamped at table end
				S_CLR: begin
					if (have_q && (rdata != '0)) begin
						used_q <= used_q - CW'(1);
					end
					if (clr_issue) begin
						iss_q  <= iss_q + CW'(1);
						cnt_q  <= cnt_q - CW'(1);
						have_q <= 1'b1;
					end else begin
						have_q <= 1'b0;
						if (!have_q) begin
							state_q <= S_MUL;
						end
					end
				end
				// usage product
				S_MUL: begin
					prod_q  <= bta_pkg::PROD_W'(used_q) * bta_pkg::PROD_W'(bta_pkg::PERMILLE);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle               = (state_q == S_IDLE);
	assign res_valid          = (state_q == S_EMIT);
	assign res.status         = status_q;
	assign res.alloc_offset   = aoff_q;
	assign res.usage_permille = prod_q[IW+bta_pkg::USAGE_W-1:IW];

endmodule

### src/block_table_allocator_unit.sv
// block table allocator: fixed-block pool of 8192 blocks of 1024 bytes
// input channel s_axis carries one request per beat: allocate a byte size
// (op 0) or free the region at a byte offset (op 1)
// output channel m_axis carries one result beat per request: status,
// allocated byte offset and pool usage in permille after the operation
// after reset the table is swept to zero, one entry a cycle, and
// s_axis_tready stays low during the sweep
// one request is worked on at a time, s_axis_tready is low until its
// result has moved into the output register, so the next beat is taken in
// the cycle after and a request holds the block for its whole latency
// an allocate scans entries from the top of the table down, then writes
// the run length over the run it found, or reports no fit if none is found
// a free reads the run length at the freed block and clears that many
// entries from it, stopping at the table end, or ends at once when that
// block is free; zero size, oversized and out-of-range requests go
// straight to the result; a stalled receiver holds the result in the
// output register and the sequencer waits before delivering the next one
module block_table_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// op, req_size, free_offset, zero pad
	input  logic [bta_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status, alloc_offset, usage_permille, zero pad
	output logic [bta_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	localparam int unsigned SZ_LO = 1;
	localparam int unsigned FO_LO = SZ_LO + bta_pkg::SIZE_W;
	localparam int unsigned RES_W = $bits(bta_pkg::res_t);

	bta_pkg::req_t  req;
	bta_pkg::res_t  res;
	logic           core_idle;
	logic           res_valid;
	logic           res_ready;
	logic           m_tvalid_q;
	bta_pkg::res_t  m_res_q;

	// unpack request beat
	assign req.op          = s_axis_tdata[0];
	assign req.req_size    = s_axis_tdata[FO_LO-1:SZ_LO];
	assign req.free_offset = s_axis_tdata[FO_LO+bta_pkg::OFF_W-1:FO_LO];

	assign s_axis_tready = core_idle;

	bta_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid && core_idle),
		.req       (req),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	// pack result beat, first field lowest
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {
		(bta_pkg::OUT_DATA_W - RES_W)'(0),
		m_res_q.usage_permille,
		m_res_q.alloc_offset,
		m_res_q.status
	};

endmodule

### tb/block_table_allocator_unit_test.sv
module block_table_allocator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bta_pkg::*;

	localparam int unsigned POOL_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
	localparam int unsigned PAD_W        = IN_DATA_W - 1 - SIZE_W - OFF_W;
	localparam int unsigned RANDOM_ITEMS = 100;
	// long receiver hold, long enough for the block to finish its request and stall
	localparam int unsigned HOLD_CYCLES  = 20000;
	localparam int unsigned HOLD_AFTER   = 30;
	// clear sweep plus every request at its worst, several times over
	localparam int unsigned CYCLE_LIMIT  = 10000000;

	// pool model: run length per block, used count and the results still owed
	class alloc_scoreboard;
		logic [CNT_W-1:0] run_len [NUM_BLOCKS];
		int unsigned used_cnt;
		int unsigned live_starts [$];
		res_t pending_results [$];
		int unsigned checked;
		int unsigned mismatches;

		function new();
			foreach (run_len[i]) run_len[i] = '0;
			used_cnt   = 0;
			checked    = 0;
			mismatches = 0;
		endfunction

		// first fit from the top of the table downward
		function status_t predict_alloc(input int unsigned size, output int unsigned offset);
			int unsigned need;
			int unsigned run;
			offset = 0;
			if (size == 0) return ST_ZERO;
			need = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
			if (need > NUM_BLOCKS) return ST_NOFIT;
			run = 0;
			for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
				if (run_len[i] == 0) run++;
				else run = 0;
				if (run == need) begin
					for (int k = 0; k < need; k++) run_len[i + k] = CNT_W'(need);
					used_cnt += need;
					offset = i * BLOCK_BYTES;
					live_starts.push_back(i);
					return ST_OK;
				end
			end
			return ST_NOFIT;
		endfunction

		// clear the stored run length worth of entries, stopping at the table end
		function status_t predict_free(input int unsigned offset);
			int unsigned start;
			int unsigned count;
			if (offset >= POOL_BYTES) return ST_RANGE;
			start = offset / BLOCK_BYTES;
			count = run_len[start];
			for (int unsigned k = 0; k < count && start + k < NUM_BLOCKS; k++) begin
				if (run_len[start + k] != 0) begin
					run_len[start + k] = '0;
					used_cnt--;
				end
			end
			return ST_OK;
		endfunction

		function void note_request(input logic op, input logic [SIZE_W-1:0] size,
				input logic [OFF_W-1:0] off);
			res_t r;
			int unsigned aoff;
			aoff = 0;
			if (op == OP_ALLOC) r.status = predict_alloc(size, aoff);
			else r.status = predict_free(off);
			r.alloc_offset   = AOFF_W'(aoff);
			r.usage_permille = USAGE_W'(used_cnt * PERMILLE / NUM_BLOCKS);
			pending_results.push_back(r);
		endfunction

		function void check_result(input logic [OUT_DATA_W-1:0] beat);
			res_t want;
			logic [1:0] got_status;
			logic [AOFF_W-1:0] got_offset;
			logic [USAGE_W-1:0] got_usage;
			got_status = beat[1:0];
			got_offset = beat[AOFF_W+1:2];
			got_usage  = beat[AOFF_W+USAGE_W+1:AOFF_W+2];
			checked++;
			if (pending_results.size() == 0) begin
				$error("result beat with no request waiting: %h", beat);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got_status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got_status);
				mismatches++;
			end
			if (got_offset !== want.alloc_offset) begin
				$error("alloc_offset expected %0d actual %0d", want.alloc_offset, got_offset);
				mismatches++;
			end
			if (got_usage !== want.usage_permille) begin
				$error("usage_permille expected %0d actual %0d", want.usage_permille,
					got_usage);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	alloc_scoreboard sb = new();

	block_table_allocator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hold reset at the start, released once
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 15);
		return $urandom_range(30, 200);
	endfunction

	// offer one request beat and wait until it is taken
	task automatic send_req(input logic op, input logic [SIZE_W-1:0] size,
			input logic [OFF_W-1:0] off);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {{PAD_W{1'b0}}, off, size, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, size, off);
	endtask

	task automatic send_alloc(input int unsigned size);
		send_req(OP_ALLOC, SIZE_W'(size), OFF_W'($urandom()));
	endtask

	task automatic send_free(input int unsigned off);
		send_req(OP_FREE, SIZE_W'($urandom()), OFF_W'(off));
	endtask

	// result beats
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// receiver: random stalls, plus one long hold to back the block up
	initial begin : receiver
		int unsigned on_left;
		int unsigned off_left;
		bit held;
		on_left  = 0;
		off_left = 0;
		held     = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sb.checked >= HOLD_AFTER) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end else if (off_left > 0) begin
				m_axis_tready <= 1'b0;
				off_left--;
			end else if (on_left > 0) begin
				m_axis_tready <= 1'b1;
				on_left--;
			end else begin
				on_left  = $urandom_range(1, 40);
				off_left = pick_gap();
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned pick;
		int unsigned idx;
		int unsigned blk;
		wait (arst_n);
		@(posedge clk);

		// size extremes, whole pool, full pool, range edges
		send_alloc(0);
		send_alloc(24'hFFFFFF);
		send_alloc(POOL_BYTES);
		send_alloc(1);
		send_free(POOL_BYTES);
		send_free(24'hFFFFFF);
		send_free(0);
		// free of a block that is already free
		send_free(0);
		// rounding to blocks near the top of the table
		send_alloc(1);
		send_alloc(BLOCK_BYTES);
		send_alloc(BLOCK_BYTES + 1);
		send_alloc(3000);
		// free inside a run that reaches into the run above it
		send_free((NUM_BLOCKS - 5) * BLOCK_BYTES + 5);
		send_free(POOL_BYTES - 1);
		send_alloc(4 * BLOCK_BYTES);
		send_free((NUM_BLOCKS - 2) * BLOCK_BYTES);
		// run start whose last entry was already cleared
		send_free((NUM_BLOCKS - 7) * BLOCK_BYTES);
		send_free((NUM_BLOCKS - 11) * BLOCK_BYTES + 1023);
		send_alloc(2 * BLOCK_BYTES);
		// free inside a run that is clipped by the table end
		send_free((NUM_BLOCKS - 1) * BLOCK_BYTES);

		// mostly alloc/free pairs on live regions, some noise and bad requests
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_alloc($urandom_range(1, 16 * BLOCK_BYTES));
			end else if (pick < 56) begin
				send_alloc($urandom_range(16 * BLOCK_BYTES + 1, 256 * BLOCK_BYTES));
			end else if (pick < 59) begin
				send_alloc($urandom_range(256 * BLOCK_BYTES + 1, 2048 * BLOCK_BYTES));
			end else if (pick < 61) begin
				send_alloc(0);
			end else if (pick < 63) begin
				send_alloc($urandom_range(POOL_BYTES + 1, 24'hFFFFFF));
			end else if (pick < 88 && sb.live_starts.size() > 0) begin
				idx = $urandom_range(0, sb.live_starts.size() - 1);
				blk = sb.live_starts[idx];
				sb.live_starts.delete(idx);
				if ($urandom_range(0, 3) == 0 && sb.run_len[blk] > 1)
					blk += $urandom_range(0, sb.run_len[blk] - 1);
				send_free(blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
			end else if (pick < 94) begin
				send_free($urandom_range(0, POOL_BYTES - 1));
			end else begin
				send_free($urandom_range(POOL_BYTES, 24'hFFFFFF));
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then a short tail for stray beats
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
